// ===== rtl/core/tlik_pkg.sv =====
package tlik_pkg;

  localparam int XW    = 24;
  localparam int LW    = 23;
  localparam int SHW   = 18;
  localparam int ELW   = 16;
  localparam int R2W   = 48;
  localparam int CW    = 64;
  localparam int ZW    = 32;
  localparam int FRACW = 30;

  localparam logic [ZW-1:0] DEG90  = 32'sd5898240;
  localparam logic [ZW-1:0] DEG180 = 32'sd11796480;
  localparam logic [CW-1:0] ONE_Q30 = 64'd1 << 30;

  typedef enum logic {
    CFG_LINK1 = 1'b0,
    CFG_LINK2 = 1'b1
  } cfg_idx_t;

  function automatic logic [ZW-1:0] atan_deg(input int i);
    logic [ZW-1:0] v;
    case (i)
      0: v = 32'd2949120;  1: v = 32'd1740967;  2: v = 32'd919879;   3: v = 32'd466945;
      4: v = 32'd234379;   5: v = 32'd117304;   6: v = 32'd58666;    7: v = 32'd29335;
      8: v = 32'd14668;    9: v = 32'd7334;     10: v = 32'd3667;    11: v = 32'd1833;
      12: v = 32'd917;     13: v = 32'd458;     14: v = 32'd229;     15: v = 32'd115;
      16: v = 32'd57;      17: v = 32'd29;      18: v = 32'd14;      19: v = 32'd7;
      20: v = 32'd4;       21: v = 32'd2;       22: v = 32'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/two_link_inverse_kinematics_core.sv =====
// Channel  | Ports                                   | Transfer
// ---------+-----------------------------------------+-------------------------------
// input    | start, busy, in_target_x/y              | start & !busy at clk rise
// result   | out_valid, out_reachable, out_*_angle   | out_valid high for one cycle
// config   | cfg_we, cfg_index, cfg_data             | cfg_we at clk rise
//
// One target enters per cycle; busy is tied low. Each target passes through the
// register stages in order: squares, a 32-step square root of r^2, a range check
// and two 30-step dividers, two parallel 32-step square roots of 1 - c^2 and three
// CORDIC chains of CORDIC_STAGES stages each, plus glue and output registers.
// rst_n is synchronous and clears only valid bits and the link registers.
// The receiver cannot stall, so nothing ever waits.
module two_link_inverse_kinematics_core
  import tlik_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [XW-1:0]  in_target_x,
  input  logic signed [XW-1:0]  in_target_y,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [LW-1:0]         cfg_data,
  output logic                  out_valid,
  output logic                  out_reachable,
  output logic signed [SHW-1:0] out_shoulder_angle,
  output logic [ELW-1:0]        out_elbow_angle
);

  localparam int NS = CORDIC_STAGES;
  localparam int DV = 31;   // divider steps: range check + 30 quotient bits
  localparam int SQ = 32;   // square root steps, one result bit (two radicand bits) each

  logic [LW-1:0] l1_r, l2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r <= LW'(25600);
      l2_r <= LW'(25600);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LINK1: l1_r <= cfg_data;
        CFG_LINK2: l2_r <= cfg_data;
        default:   l1_r <= l1_r;
      endcase
    end
  end

  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Stage A: squares and reach test. Item payload carried as a struct.
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic                 reach;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [R2W-1:0]       r2;
    logic signed [CW-1:0] num_e;   // l1^2 + l2^2 - r2
    logic [CW-1:0]        den_e;   // 2 l1 l2
    logic [CW-1:0]        l1sq;
    logic [CW-1:0]        l2sq;
    logic [LW-1:0]        l1;
  } sa_t;

  logic sa_v_r;
  sa_t  sa_r;
  sa_t  sa_nxt;

  always_comb begin
    logic [R2W-1:0] xx, yy;
    logic [LW:0]    sum, dif;
    logic [CW-1:0]  s2, d2;
    xx  = R2W'($signed(in_target_x) * $signed(in_target_x));
    yy  = R2W'($signed(in_target_y) * $signed(in_target_y));
    sum = {1'b0, l1_r} + {1'b0, l2_r};
    dif = (l1_r > l2_r) ? {1'b0, l1_r - l2_r} : {1'b0, l2_r - l1_r};
    s2  = CW'(sum) * CW'(sum);
    d2  = CW'(dif) * CW'(dif);
    sa_nxt.x     = in_target_x;
    sa_nxt.y     = in_target_y;
    sa_nxt.r2    = xx + yy;
    sa_nxt.l1sq  = CW'(l1_r) * CW'(l1_r);
    sa_nxt.l2sq  = CW'(l2_r) * CW'(l2_r);
    sa_nxt.reach = !((CW'(xx + yy) > s2) || (CW'(xx + yy) < d2));
    sa_nxt.den_e = (CW'(l1_r) * CW'(l2_r)) << 1;
    sa_nxt.num_e = $signed(sa_nxt.l1sq + sa_nxt.l2sq) - $signed(CW'(xx + yy));
    sa_nxt.l1    = l1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sa_v_r <= 1'b0;
    else        sa_v_r <= start;
  end
  always_ff @(posedge clk) sa_r <= sa_nxt;

  // ---------------------------------------------------------------------
  // Square root of r2<<16, one result bit per stage (restoring).
  // ---------------------------------------------------------------------
  typedef struct packed {
    sa_t            a;
    logic [CW-1:0]  rem;
    logic [CW-1:0]  root;
    logic [CW-1:0]  v;
  } sr_t;

  sr_t  sr_r [SQ+1];
  logic sr_v_r [SQ+1];

  always_comb begin
    sr_r[0].a    = sa_r;
    sr_r[0].rem  = '0;
    sr_r[0].root = '0;
    sr_r[0].v    = CW'(sa_r.r2) << 16;
    sr_v_r[0]    = sa_v_r;
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sq
    sr_t s_nxt;
    always_comb begin
      logic [CW+1:0] rem2, trial;
      s_nxt = sr_r[k];
      rem2  = {sr_r[k].rem, sr_r[k].v[CW-1 -: 2]};
      trial = {sr_r[k].root, 2'b01};
      s_nxt.v = sr_r[k].v << 2;
      if (rem2 >= trial) begin
        s_nxt.rem  = CW'(rem2 - trial);
        s_nxt.root = {sr_r[k].root[CW-2:0], 1'b1};
      end else begin
        s_nxt.rem  = CW'(rem2);
        s_nxt.root = {sr_r[k].root[CW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) sr_v_r[k+1] <= 1'b0;
      else        sr_v_r[k+1] <= sr_v_r[k];
    end
    always_ff @(posedge clk) sr_r[k+1] <= s_nxt;
  end

  // ---------------------------------------------------------------------
  // Stage B: second cosine numerator/denominator.
  // ---------------------------------------------------------------------
  typedef struct packed {
    sa_t                  a;
    logic signed [CW-1:0] num_p;
    logic [CW-1:0]        den_p;
  } sb_t;

  logic sb_v_r;
  sb_t  sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sb_v_r <= 1'b0;
    else        sb_v_r <= sr_v_r[SQ];
  end
  always_ff @(posedge clk) begin
    sb_r.a     <= sr_r[SQ].a;
    sb_r.num_p <= ($signed(sr_r[SQ].a.l1sq) + $signed(CW'(sr_r[SQ].a.r2))
                   - $signed(sr_r[SQ].a.l2sq)) <<< 8;
    sb_r.den_p <= (CW'(sr_r[SQ].a.l1) * CW'(sr_r[SQ].root[31:0])) << 1;
  end

  // ---------------------------------------------------------------------
  // Dual divider: both cosines as Q30, one quotient bit per stage.
  // ---------------------------------------------------------------------
  typedef struct packed {
    sa_t            a;
    logic           neg_e, sat_e;
    logic           neg_p, sat_p;
    logic [CW-1:0]  den_e, rem_e;
    logic [CW-1:0]  den_p, rem_p;
    logic [FRACW-1:0] q_e, q_p;
  } dv_t;

  dv_t  dv_r [DV];
  logic dv_v_r [DV];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else        dv_v_r[0] <= sb_v_r;
  end
  always_ff @(posedge clk) begin
    logic [CW-1:0] me, mp;
    me = sb_r.a.num_e[CW-1] ? CW'(-sb_r.a.num_e) : CW'(sb_r.a.num_e);
    mp = sb_r.num_p[CW-1] ? CW'(-sb_r.num_p) : CW'(sb_r.num_p);
    dv_r[0].a     <= sb_r.a;
    dv_r[0].neg_e <= sb_r.a.num_e[CW-1];
    dv_r[0].neg_p <= sb_r.num_p[CW-1];
    dv_r[0].sat_e <= (sb_r.a.den_e == '0) || (me >= sb_r.a.den_e);
    dv_r[0].sat_p <= (sb_r.den_p == '0) || (mp >= sb_r.den_p);
    dv_r[0].den_e <= sb_r.a.den_e;
    dv_r[0].den_p <= sb_r.den_p;
    dv_r[0].rem_e <= me;
    dv_r[0].rem_p <= mp;
    dv_r[0].q_e   <= '0;
    dv_r[0].q_p   <= '0;
  end

  for (genvar k = 0; k < DV-1; k++) begin : g_dv
    dv_t d_nxt;
    always_comb begin
      logic [CW:0] re, rp;
      d_nxt = dv_r[k];
      re = {dv_r[k].rem_e, 1'b0};
      rp = {dv_r[k].rem_p, 1'b0};
      if (re >= {1'b0, dv_r[k].den_e}) begin
        d_nxt.rem_e = CW'(re - {1'b0, dv_r[k].den_e});
        d_nxt.q_e   = {dv_r[k].q_e[FRACW-2:0], 1'b1};
      end else begin
        d_nxt.rem_e = CW'(re);
        d_nxt.q_e   = {dv_r[k].q_e[FRACW-2:0], 1'b0};
      end
      if (rp >= {1'b0, dv_r[k].den_p}) begin
        d_nxt.rem_p = CW'(rp - {1'b0, dv_r[k].den_p});
        d_nxt.q_p   = {dv_r[k].q_p[FRACW-2:0], 1'b1};
      end else begin
        d_nxt.rem_p = CW'(rp);
        d_nxt.q_p   = {dv_r[k].q_p[FRACW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[k+1] <= 1'b0;
      else        dv_v_r[k+1] <= dv_v_r[k];
    end
    always_ff @(posedge clk) dv_r[k+1] <= d_nxt;
  end

  // ---------------------------------------------------------------------
  // Stage C: signed cosines, squared remainders 2^60 - c^2.
  // ---------------------------------------------------------------------
  typedef struct packed {
    sa_t                  a;
    logic signed [CW-1:0] ce;
    logic signed [CW-1:0] cp;
  } sc_t;

  sc_t  sc_nxt, sc_r;
  logic sc_v_r;

  always_comb begin
    logic [CW-1:0] me, mp;
    me = dv_r[DV-1].sat_e ? ONE_Q30 : CW'(dv_r[DV-1].q_e);
    mp = dv_r[DV-1].sat_p ? ONE_Q30 : CW'(dv_r[DV-1].q_p);
    sc_nxt.a  = dv_r[DV-1].a;
    sc_nxt.ce = dv_r[DV-1].neg_e ? -$signed(me) : $signed(me);
    sc_nxt.cp = dv_r[DV-1].neg_p ? -$signed(mp) : $signed(mp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sc_v_r <= 1'b0;
    else        sc_v_r <= dv_v_r[DV-1];
  end
  always_ff @(posedge clk) sc_r <= sc_nxt;

  // Squares: 31x31 bit magnitude products, registered.
  typedef struct packed {
    sc_t           c;
    logic [CW-1:0] ve;
    logic [CW-1:0] vp;
  } sd_t;

  sd_t  q_r;
  logic q_v_r;
  sd_t  s2_r [SQ+1];
  logic s2_v_r [SQ+1];
  logic [CW-1:0] re_r [SQ+1], rp_r [SQ+1], oe_r [SQ+1], op_r [SQ+1];

  always_ff @(posedge clk) begin
    logic [FRACW:0] ae, ap;
    ae = sc_r.ce[CW-1] ? (FRACW+1)'(-sc_r.ce) : (FRACW+1)'(sc_r.ce);
    ap = sc_r.cp[CW-1] ? (FRACW+1)'(-sc_r.cp) : (FRACW+1)'(sc_r.cp);
    q_r.c  <= sc_r;
    q_r.ve <= (CW'(1) << 60) - CW'(ae) * CW'(ae);
    q_r.vp <= (CW'(1) << 60) - CW'(ap) * CW'(ap);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) q_v_r <= 1'b0;
    else        q_v_r <= sc_v_r;
  end

  always_comb begin
    s2_r[0]   = q_r;
    s2_v_r[0] = q_v_r;
    re_r[0] = '0; rp_r[0] = '0; oe_r[0] = '0; op_r[0] = '0;
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sq2
    logic [CW-1:0] re_n, rp_n, oe_n, op_n;
    always_comb begin
      logic [CW+1:0] a2, b2, ta, tb;
      a2 = {re_r[k], s2_r[k].ve[CW-1-2*k -: 2]};
      b2 = {rp_r[k], s2_r[k].vp[CW-1-2*k -: 2]};
      ta = {oe_r[k], 2'b01};
      tb = {op_r[k], 2'b01};
      if (a2 >= ta) begin
        re_n = CW'(a2 - ta); oe_n = {oe_r[k][CW-2:0], 1'b1};
      end else begin
        re_n = CW'(a2);      oe_n = {oe_r[k][CW-2:0], 1'b0};
      end
      if (b2 >= tb) begin
        rp_n = CW'(b2 - tb); op_n = {op_r[k][CW-2:0], 1'b1};
      end else begin
        rp_n = CW'(b2);      op_n = {op_r[k][CW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) s2_v_r[k+1] <= 1'b0;
      else        s2_v_r[k+1] <= s2_v_r[k];
    end
    always_ff @(posedge clk) begin
      s2_r[k+1] <= s2_r[k];
      re_r[k+1] <= re_n;
      rp_r[k+1] <= rp_n;
      oe_r[k+1] <= oe_n;
      op_r[k+1] <= op_n;
    end
  end

  // ---------------------------------------------------------------------
  // Three CORDIC vectoring chains in parallel: elbow acos, psi acos, atan2.
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cv_t;

  typedef struct packed {
    logic reach;
    cv_t  e;
    cv_t  p;
    cv_t  t;
  } cs_t;

  cs_t  cs_r [NS+1];
  logic cs_v_r [NS+1];

  function automatic cv_t pre_rot(input logic signed [CW-1:0] y,
                                  input logic signed [CW-1:0] x);
    cv_t o;
    o.x = x; o.y = y; o.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        o.x = y; o.y = -x; o.z = DEG90;
      end else begin
        o.x = -y; o.y = x; o.z = -DEG90;
      end
    end
    return o;
  endfunction

  function automatic cv_t rot(input cv_t c, input int i);
    cv_t o;
    logic signed [CW-1:0] dx, dy;
    o  = c;
    dx = c.y >>> i;
    dy = c.x >>> i;
    if (c.y > 0) begin
      o.x = c.x + dx; o.y = c.y - dy; o.z = c.z + atan_deg(i);
    end else if (c.y < 0) begin
      o.x = c.x - dx; o.y = c.y + dy; o.z = c.z - atan_deg(i);
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) cs_v_r[0] <= 1'b0;
    else        cs_v_r[0] <= s2_v_r[SQ];
  end
  always_ff @(posedge clk) begin
    logic signed [CW-1:0] tx, ty;
    tx = $signed(s2_r[SQ].c.a.x) * $signed(CW'(ONE_Q30));
    ty = $signed(s2_r[SQ].c.a.y) * $signed(CW'(ONE_Q30));
    cs_r[0].reach <= s2_r[SQ].c.a.reach;
    cs_r[0].e <= pre_rot($signed(oe_r[SQ]), s2_r[SQ].c.ce);
    cs_r[0].p <= pre_rot($signed(op_r[SQ]), s2_r[SQ].c.cp);
    cs_r[0].t <= pre_rot(ty, tx);
  end

  for (genvar k = 0; k < NS; k++) begin : g_cd
    always_ff @(posedge clk) begin
      if (!rst_n) cs_v_r[k+1] <= 1'b0;
      else        cs_v_r[k+1] <= cs_v_r[k];
    end
    always_ff @(posedge clk) begin
      cs_r[k+1].reach <= cs_r[k].reach;
      cs_r[k+1].e     <= rot(cs_r[k].e, k);
      cs_r[k+1].p     <= rot(cs_r[k].p, k);
      cs_r[k+1].t     <= rot(cs_r[k].t, k);
    end
  end

  // ---------------------------------------------------------------------
  // Output: clamps, rounding to Q.8, zero angles when unreachable.
  // ---------------------------------------------------------------------
  logic signed [ZW-1:0] ze, zp, zt;
  logic signed [ZW-1:0] sh_raw, el_raw;
  logic                 out_v_r, out_reach_r;
  logic signed [SHW-1:0] out_sh_r;
  logic [ELW-1:0]        out_el_r;

  always_comb begin
    logic signed [ZW-1:0] a0, a1, a2;
    a0 = cs_r[NS].e.z;
    a1 = cs_r[NS].p.z;
    a2 = cs_r[NS].t.z;
    ze = (a0 < 0) ? '0 : ((a0 > $signed(DEG180)) ? $signed(DEG180) : a0);
    zp = (a1 < 0) ? '0 : ((a1 > $signed(DEG180)) ? $signed(DEG180) : a1);
    zt = (a2 < -$signed(DEG180)) ? -$signed(DEG180) :
         ((a2 > $signed(DEG180)) ? $signed(DEG180) : a2);
    sh_raw = (zt - zp + 32'sd128) >>> 8;
    el_raw = (ze + 32'sd128) >>> 8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else        out_v_r <= cs_v_r[NS];
  end
  always_ff @(posedge clk) begin
    out_reach_r <= cs_r[NS].reach;
    if (!cs_r[NS].reach) begin
      out_sh_r <= '0;
      out_el_r <= '0;
    end else begin
      out_sh_r <= (sh_raw < -32'sd92160) ? SHW'(-92160) :
                  ((sh_raw > 32'sd46080) ? SHW'(46080) : SHW'(sh_raw));
      out_el_r <= (el_raw > 32'sd46080) ? ELW'(46080) : ELW'(el_raw);
    end
  end

  assign out_valid          = out_v_r;
  assign out_reachable      = out_reach_r;
  assign out_shoulder_angle = out_sh_r;
  assign out_elbow_angle    = out_el_r;

  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reachable |-> out_shoulder_angle == '0 && out_elbow_angle == '0)
    else $error("unreachable result carries nonzero angle");
  a_elbow_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_elbow_angle <= ELW'(46080))
    else $error("elbow angle out of range");
  a_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cs_v_r[NS] |=> out_valid)
    else $error("result lost at output stage");

endmodule
